// File: rtl/linear_probe_hash_cache_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash cache
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_CACHE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_CACHE_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LPHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphc checker: property failed");

// Consequence must hold in the cycle after the antecedent.
`define LPHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphc checker: property failed");

`endif

// File: rtl/lphc_pkg.sv
// ----------------------------------------------------------------------------
// lphc_pkg
// Types and constants shared by the hash cache controller and datapath.
// ----------------------------------------------------------------------------
package lphc_pkg;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 64;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 7;
   // The remainder unit consumes this many key bits per cycle.
   localparam int NIB_W      = 4;
   localparam int HASH_STEPS = KEY_W / NIB_W;
   localparam int HASH_CNT_W = $clog2(HASH_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_PRESENT  = 3'd3,
      ST_EVICTED  = 3'd4,
      ST_REMOVED  = 3'd5,
      ST_NOTFOUND = 3'd6,
      ST_CLEARED  = 3'd7
   } status_type;

   // Which handle and slot accompany a result.
   typedef enum logic [1:0] {
      RES_NONE       = 2'd0,
      RES_CHK_HANDLE = 2'd1,
      RES_CHK_SLOT   = 2'd2,
      RES_EVICT      = 2'd3
   } res_kind_type;

   typedef enum logic [2:0] {
      S_INIT  = 3'd0,
      S_IDLE  = 3'd1,
      S_HASH  = 3'd2,
      S_PROBE = 3'd3,
      S_CLEAR = 3'd4,
      S_DONE  = 3'd5
   } state_type;

   typedef struct packed {
      logic         load;
      logic         hash_step;
      logic         probe_step;
      logic         sweep_step;
      logic         wr_insert;
      logic         wr_evict;
      logic         wr_remove;
      logic         res_load;
      status_type   res_status;
      res_kind_type res_kind;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type req_op;
      logic   req_key_zero;
      op_type op;
      logic   hash_last;
      logic   slot_empty;
      logic   slot_match;
      logic   lap_last;
      logic   sweep_last;
      logic   rsp_free;
   } stat_type;

endpackage

// File: rtl/lphc_ctrl.sv
// ----------------------------------------------------------------------------
// lphc_ctrl
// Sequencer for the hash cache: sweep, remainder, probe and result hand-off.
// ----------------------------------------------------------------------------
module lphc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lphc_pkg::stat_type stat,
   output lphc_pkg::cmd_type  cmd
);
   import lphc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.req_op == OP_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (stat.req_key_zero) begin
                  // A zero key never probes the table.
                  cmd.res_load   = 1'b1;
                  cmd.res_kind   = RES_NONE;
                  cmd.res_status = (stat.req_op == OP_REMOVE) ? ST_NOTFOUND : ST_MISS;
                  state_in       = S_DONE;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_last) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            unique case (stat.op)
               OP_FIND: begin
                  if (stat.slot_empty || (stat.lap_last && !stat.slot_match)) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_MISS;
                     cmd.res_kind   = RES_NONE;
                  end else if (stat.slot_match) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_HIT;
                     cmd.res_kind   = RES_CHK_HANDLE;
                  end
               end
               OP_INSERT: begin
                  if (stat.slot_empty) begin
                     cmd.wr_insert  = 1'b1;
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_INSERTED;
                     cmd.res_kind   = RES_CHK_SLOT;
                  end else if (stat.slot_match) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_PRESENT;
                     cmd.res_kind   = RES_CHK_SLOT;
                  end else if (stat.lap_last) begin
                     cmd.wr_evict   = 1'b1;
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_EVICTED;
                     cmd.res_kind   = RES_EVICT;
                  end
               end
               OP_REMOVE: begin
                  if (stat.slot_match) begin
                     cmd.wr_remove  = 1'b1;
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_REMOVED;
                     cmd.res_kind   = RES_CHK_HANDLE;
                  end else if (stat.lap_last) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_NOTFOUND;
                     cmd.res_kind   = RES_NONE;
                  end
               end
               OP_CLEAR: begin
                  // Clear is handled by the sweep and never probes.
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_CLEARED;
                  cmd.res_kind   = RES_NONE;
               end
            endcase
            if (cmd.res_load) begin
               state_in = S_DONE;
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_CLEARED;
               cmd.res_kind   = RES_NONE;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// File: rtl/lphc_datapath.sv
// ----------------------------------------------------------------------------
// lphc_datapath
// Key and handle memories, key remainder unit, probe pipeline, result regs.
// ----------------------------------------------------------------------------
module lphc_datapath #(
   parameter int TABLE_SIZE = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lphc_pkg::OP_W-1:0]       req_operation,
   input  logic [lphc_pkg::KEY_W-1:0]      req_key,
   input  logic [lphc_pkg::HANDLE_W-1:0]   req_handle_in,
   input  lphc_pkg::cmd_type               cmd,
   output lphc_pkg::stat_type              stat,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [lphc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lphc_pkg::HANDLE_W-1:0]   rsp_handle_out,
   output logic [lphc_pkg::SLOT_W-1:0]     rsp_slot
);
   import lphc_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int RW = IW + NIB_W;
   localparam logic [IW-1:0]         LAST_IDX  = IW'(TABLE_SIZE - 1);
   localparam logic [HASH_CNT_W-1:0] LAST_HASH = HASH_CNT_W'(HASH_STEPS - 1);

   logic [KEY_W-1:0]    key_mem [TABLE_SIZE];
   logic [HANDLE_W-1:0] handle_mem [TABLE_SIZE];

   op_type                op_ff,         op_in;
   logic [KEY_W-1:0]      key_ff,        key_in;
   logic [HANDLE_W-1:0]   hin_ff,        hin_in;
   logic [KEY_W-1:0]      kshift_ff,     kshift_in;
   logic [IW-1:0]         rem_ff,        rem_in;
   logic [HASH_CNT_W-1:0] hash_cnt_ff,   hash_cnt_in;
   logic [IW-1:0]         rd_idx_ff,     rd_idx_in;
   logic [IW-1:0]         chk_idx_ff,    chk_idx_in;
   logic [IW-1:0]         chk_cnt_ff,    chk_cnt_in;
   logic                  chk_valid_ff,  chk_valid_in;
   logic [HANDLE_W-1:0]   first_hdl_ff,  first_hdl_in;
   logic [IW-1:0]         sweep_ff,      sweep_in;
   status_type            res_status_ff, res_status_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;
   logic [SLOT_W-1:0]     res_slot_ff,   res_slot_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [SLOT_W-1:0]     rsp_slot_ff,   rsp_slot_in;

   logic [KEY_W-1:0]    key_rd_ff;
   logic [HANDLE_W-1:0] handle_rd_ff;

   logic [RW-1:0]       rem_ext;
   logic                key_we;
   logic                handle_we;
   logic [IW-1:0]       wr_addr;
   logic [KEY_W-1:0]    key_wdata;

   // One remainder digit: fold four key bits in, then reduce below the table size.
   always_comb begin
      rem_ext = {rem_ff, kshift_ff[KEY_W-1 -: NIB_W]};
      for (int k = NIB_W - 1; k >= 0; k--) begin
         if (rem_ext >= (RW'(TABLE_SIZE) << k)) begin
            rem_ext = rem_ext - (RW'(TABLE_SIZE) << k);
         end
      end
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      hin_in        = hin_ff;
      kshift_in     = kshift_ff;
      rem_in        = rem_ff;
      hash_cnt_in   = hash_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_cnt_in    = chk_cnt_ff;
      chk_valid_in  = chk_valid_ff;
      first_hdl_in  = first_hdl_ff;
      sweep_in      = sweep_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_slot_in   = res_slot_ff;

      if (cmd.load) begin
         op_in       = op_type'(req_operation);
         key_in      = req_key;
         hin_in      = req_handle_in;
         kshift_in   = req_key;
         rem_in      = '0;
         hash_cnt_in = '0;
      end
      if (cmd.hash_step) begin
         kshift_in    = kshift_ff << NIB_W;
         rem_in       = rem_ext[IW-1:0];
         hash_cnt_in  = hash_cnt_ff + 1'b1;
         rd_idx_in    = rem_ext[IW-1:0];
         chk_valid_in = 1'b0;
      end
      if (cmd.probe_step) begin
         rd_idx_in    = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
         chk_idx_in   = rd_idx_ff;
         chk_valid_in = 1'b1;
         chk_cnt_in   = chk_valid_ff ? chk_cnt_ff + 1'b1 : '0;
         if (chk_valid_ff && (chk_cnt_ff == '0)) begin
            first_hdl_in = handle_rd_ff;
         end
      end
      if (cmd.sweep_step) begin
         sweep_in = (sweep_ff == LAST_IDX) ? '0 : sweep_ff + 1'b1;
      end
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         case (cmd.res_kind)
            RES_CHK_HANDLE: begin
               res_handle_in = handle_rd_ff;
               res_slot_in   = SLOT_W'(chk_idx_ff);
            end
            RES_CHK_SLOT: begin
               res_handle_in = '0;
               res_slot_in   = SLOT_W'(chk_idx_ff);
            end
            RES_EVICT: begin
               res_handle_in = first_hdl_ff;
               res_slot_in   = SLOT_W'(rem_ff);
            end
            default: begin
               res_handle_in = '0;
               res_slot_in   = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_handle_in = res_handle_ff;
         rsp_slot_in   = res_slot_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      hin_ff        <= hin_in;
      kshift_ff     <= kshift_in;
      rem_ff        <= rem_in;
      hash_cnt_ff   <= hash_cnt_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      chk_cnt_ff    <= chk_cnt_in;
      first_hdl_ff  <= first_hdl_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Single write port shared by the sweep, insert, evict and remove.
   always_comb begin
      key_we    = cmd.sweep_step | cmd.wr_insert | cmd.wr_evict | cmd.wr_remove;
      handle_we = cmd.wr_insert | cmd.wr_evict;
      if (cmd.sweep_step) begin
         wr_addr = sweep_ff;
      end else if (cmd.wr_evict) begin
         wr_addr = rem_ff;
      end else begin
         wr_addr = chk_idx_ff;
      end
      key_wdata = handle_we ? key_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_wdata;
      end
      key_rd_ff <= key_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (handle_we) begin
         handle_mem[wr_addr] <= hin_ff;
      end
      handle_rd_ff <= handle_mem[rd_idx_ff];
   end

   always_comb begin
      stat.req_op       = op_type'(req_operation);
      stat.req_key_zero = (req_key == '0);
      stat.op           = op_ff;
      stat.hash_last    = (hash_cnt_ff == LAST_HASH);
      stat.slot_empty   = chk_valid_ff && (key_rd_ff == '0);
      stat.slot_match   = chk_valid_ff && (key_rd_ff == key_ff);
      stat.lap_last     = chk_valid_ff && (chk_cnt_ff == LAST_IDX);
      stat.sweep_last   = (sweep_ff == LAST_IDX);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_slot       = rsp_slot_ff;

endmodule

// File: rtl/linear_probe_hash_cache_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_cache_unit
// Open-addressed cache of nonzero 64-bit keys with 16-bit handles, probed
// linearly from key mod TABLE_SIZE.
// ----------------------------------------------------------------------------
//   Channel | Direction | Beat contents
//   req_    | in        | operation, key, handle_in
//   rsp_    | out       | status, handle_out, slot
//
// After reset the key memory is cleared by a sweep over all TABLE_SIZE slots,
// during which req_ready stays low. A find, insert or remove is accepted, runs
// through the remainder unit (four key bits per cycle), probes the slots in turn
// behind a registered memory read, and then hands its result to the output
// register. A clear sweeps every slot through the single memory write port. A
// zero key of a find, insert or remove is answered without a probe. A result
// held by a stalled rsp_ready does not stop the next request from being
// accepted and worked on; only its hand-off waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_cache_unit #(
   parameter int TABLE_SIZE = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lphc_pkg::OP_W-1:0]       req_operation,
   input  logic [lphc_pkg::KEY_W-1:0]      req_key,
   input  logic [lphc_pkg::HANDLE_W-1:0]   req_handle_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lphc_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lphc_pkg::HANDLE_W-1:0]   rsp_handle_out,
   output logic [lphc_pkg::SLOT_W-1:0]     rsp_slot
);
   import lphc_pkg::*;

   // Commands flow from the sequencer into the datapath; status flows back.
   cmd_type  cmd;
   stat_type stat;

   // The sequencer owns req_ready: a beat is only taken while it is idle.
   lphc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds both memories, the remainder unit, the probe pipeline
   // and the output register that separates the result side from the request
   // side.
   lphc_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_handle_in  (req_handle_in),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot       (rsp_slot)
   );

endmodule

// File: rtl/lphc_checker.sv
// ----------------------------------------------------------------------------
// lphc_checker
// Port-level properties of the hash cache, bound onto the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_cache_unit_assert.svh"

module lphc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [lphc_pkg::OP_W-1:0]       req_operation,
   input logic [lphc_pkg::KEY_W-1:0]      req_key,
   input logic [lphc_pkg::HANDLE_W-1:0]   req_handle_in,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lphc_pkg::STATUS_W-1:0]   rsp_status,
   input logic [lphc_pkg::HANDLE_W-1:0]   rsp_handle_out,
   input logic [lphc_pkg::SLOT_W-1:0]     rsp_slot
);
   import lphc_pkg::*;

   // A stalled result beat keeps its contents.
   `LPHC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_handle_out) && $stable(rsp_slot))

   // req_ready is low in the cycle after every accepted request.
   `LPHC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // Results without a slot carry neither handle nor slot.
   `LPHC_ASSERT_SAME(a_empty_result, clock, reset, rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_NOTFOUND || rsp_status == ST_CLEARED), rsp_handle_out == '0 && rsp_slot == '0)

   // Insert results other than eviction return no handle.
   `LPHC_ASSERT_SAME(a_insert_no_handle, clock, reset, rsp_valid && (rsp_status == ST_INSERTED || rsp_status == ST_PRESENT), rsp_handle_out == '0)

endmodule

bind linear_probe_hash_cache_unit lphc_checker u_lphc_checker (.*);

// File: tb/sv/linear_probe_hash_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// Linear probing hash cache testbench
// Drives find, insert, remove and clear beats into the cache and checks every
// response against an in-bench model of the open-addressed key table.
// ----------------------------------------------------------------------------
module linear_probe_hash_cache_unit_tb;

   import lphc_pkg::*;

   localparam int TABLE_SIZE   = 128;
   localparam int RANDOM_ITEMS = 1500;
   // Upper bound on the number of request beats: directed part, random part
   // and the overshoot of the last random episode.
   localparam int MAX_ITEMS    = 1800;
   localparam int MAX_GAP      = 12;
   // Longest receiver stall that the ready patterns are expected to produce.
   localparam int MAX_STALL    = 16;
   // Slowest beat: full lap plus fixed overhead, sender gap and receiver stall.
   // The whole bound is taken four times over and covers the clearing sweep.
   localparam int CYCLE_LIMIT  =
      4 * (MAX_ITEMS * (TABLE_SIZE + 19 + MAX_GAP + MAX_STALL) + TABLE_SIZE + 1000);
   localparam int MAX_PRINTED  = 100;

   localparam logic [KEY_W-1:0] KEY_TOP  = '1;                     // starts at the last slot
   localparam logic [KEY_W-1:0] KEY_WRAP = 64'd255;                // also starts at the last slot
   localparam logic [KEY_W-1:0] KEY_MSB  = 64'h8000_0000_0000_0000; // starts at slot zero

   typedef struct {
      status_type            status;
      logic [HANDLE_W-1:0]   handle;
      logic [SLOT_W-1:0]     slot;
   } cache_result_t;

   typedef enum int {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_style_t;
   typedef enum int {EP_CLUSTER, EP_FILL, EP_NOISE, EP_QUIESCE} episode_t;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the key and handle tables, works out
   // the response of every accepted request beat and compares the responses
   // in order.
   // -------------------------------------------------------------------------
   class hash_cache_scoreboard;
      logic [KEY_W-1:0]    key_slots    [TABLE_SIZE];
      logic [HANDLE_W-1:0] handle_slots [TABLE_SIZE];
      cache_result_t       expected_results [$];
      int                  error_count;
      int                  printed;
      int                  checked;

      function new();
         foreach (key_slots[i]) begin
            key_slots[i]    = '0;
            handle_slots[i] = '0;
         end
         error_count = 0;
         printed     = 0;
         checked     = 0;
      endfunction

      function int pending_count();
         return expected_results.size();
      endfunction

      // Applies one access to the table copy and returns the response it causes.
      function cache_result_t access_table(op_type op, logic [KEY_W-1:0] key,
                                           logic [HANDLE_W-1:0] hnd);
         cache_result_t res;
         int unsigned   start_slot;
         int unsigned   probe;
         bit            done;
         res.status = ST_MISS;
         res.handle = '0;
         res.slot   = '0;
         start_slot = int'(key % TABLE_SIZE);
         probe      = start_slot;
         done       = 1'b0;
         case (op)
            OP_CLEAR: begin
               foreach (key_slots[i]) key_slots[i] = '0;
               res.status = ST_CLEARED;
            end
            OP_FIND: begin
               if (key != '0) begin
                  for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                     if (key_slots[probe] == '0) begin
                        done = 1'b1;
                     end else if (key_slots[probe] == key) begin
                        res.status = ST_HIT;
                        res.handle = handle_slots[probe];
                        res.slot   = SLOT_W'(probe);
                        done       = 1'b1;
                     end else begin
                        probe = (probe + 1) % TABLE_SIZE;
                     end
                  end
               end
            end
            OP_INSERT: begin
               if (key != '0) begin
                  for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                     if (key_slots[probe] == '0) begin
                        key_slots[probe]    = key;
                        handle_slots[probe] = hnd;
                        res.status = ST_INSERTED;
                        res.slot   = SLOT_W'(probe);
                        done       = 1'b1;
                     end else if (key_slots[probe] == key) begin
                        res.status = ST_PRESENT;
                        res.slot   = SLOT_W'(probe);
                        done       = 1'b1;
                     end else begin
                        probe = (probe + 1) % TABLE_SIZE;
                     end
                  end
                  // A full lap with no hole and no match evicts the start slot.
                  if (!done) begin
                     res.status = ST_EVICTED;
                     res.handle = handle_slots[start_slot];
                     res.slot   = SLOT_W'(start_slot);
                     key_slots[start_slot]    = key;
                     handle_slots[start_slot] = hnd;
                  end
               end
            end
            default: begin
               // Remove walks the whole lap, since holes do not end the search.
               res.status = ST_NOTFOUND;
               if (key != '0) begin
                  for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                     if (key_slots[probe] == key) begin
                        res.status = ST_REMOVED;
                        res.handle = handle_slots[probe];
                        res.slot   = SLOT_W'(probe);
                        key_slots[probe] = '0;
                        done       = 1'b1;
                     end else begin
                        probe = (probe + 1) % TABLE_SIZE;
                     end
                  end
               end
            end
         endcase
         return res;
      endfunction

      function void note_request(op_type op, logic [KEY_W-1:0] key,
                                 logic [HANDLE_W-1:0] hnd);
         expected_results.push_back(access_table(op, key, hnd));
      endfunction

      task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
         error_count++;
         if (printed < MAX_PRINTED) begin
            printed++;
            $display("mismatch on response %0d: %0s got %0h expected %0h",
                     checked, what, got, want);
         end
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] hnd,
                          logic [SLOT_W-1:0] slot);
         cache_result_t want;
         checked++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response, status", status, '0);
         end else begin
            want = expected_results.pop_front();
            if (status !== want.status) report_mismatch("status", status, want.status);
            if (hnd !== want.handle) report_mismatch("handle", hnd, want.handle);
            if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [HANDLE_W-1:0] req_handle_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [SLOT_W-1:0]   rsp_slot;

   hash_cache_scoreboard sb = new();

   // Sender burst bookkeeping and receiver stall pattern state.
   int           burst_left = 0;
   int           items_sent = 0;
   ready_style_t ready_style = RDY_OPEN;
   int           style_left = 0;
   int           stall_period = 2;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   linear_probe_hash_cache_unit #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot       (rsp_slot)
   );

   // -------------------------------------------------------------------------
   // Beat monitor. Both channels are sampled at the rising edge, before any
   // nonblocking update of that edge lands, so the values seen are the ones
   // the block saw. A request beat is modeled the moment it is accepted.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_status, rsp_handle_out, rsp_slot);
         end
         if (req_valid && req_ready) begin
            sb.note_request(op_type'(req_operation), req_key, req_handle_in);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. The ready pattern switches now and then, at random, between
   // always ready, a coin toss, a sparse ready and a fixed-period ready, so
   // that stalls land on every phase of the block's work and there are long
   // stretches with no stall at all.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style  = ready_style_t'($urandom_range(0, 3));
         style_left   = $urandom_range(40, 400);
         stall_period = $urandom_range(2, 9);
      end
      style_left--;
      case (ready_style)
         RDY_OPEN:   rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= (style_left % stall_period == 0);
      endcase
   end

   // -------------------------------------------------------------------------
   // Watchdog: a hung handshake ends the run as a failure.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Presents one request beat and returns at the edge that accepts it. The
   // sender works in bursts; between bursts valid may drop for a random gap.
   // Must be called at a rising edge.
   task automatic send_item(input op_type op, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] hnd);
      int idle_gap;
      if (burst_left == 0) begin
         idle_gap = $urandom_range(0, MAX_GAP);
         if (idle_gap > 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_handle_in <= hnd;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Holds the sender off until every outstanding response has been taken.
   // The queue is read at the falling edge, after the monitor has run.
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (sb.pending_count() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [KEY_W-1:0] pool [$];
      logic [KEY_W-1:0] k;
      episode_t         kind;
      int               episode;
      int               length;
      int               pick;
      int               base;
      int               random_start;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A zero key is answered without touching the table.
      send_item(OP_FIND,   '0, '0);
      send_item(OP_INSERT, '0, 16'hFFFF);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_FIND,   64'd1, '0);
      // Two keys that share the last slot: the second one wraps to slot zero.
      send_item(OP_INSERT, KEY_TOP, 16'hFFFF);
      send_item(OP_INSERT, KEY_WRAP, 16'h0000);
      send_item(OP_INSERT, KEY_TOP, 16'h1234);
      send_item(OP_FIND,   KEY_WRAP, '0);
      send_item(OP_FIND,   KEY_TOP, '0);
      // Removing the first key leaves a hole in front of the wrapped one, so
      // a find misses it and an insert stores it a second time.
      send_item(OP_REMOVE, KEY_TOP, '0);
      send_item(OP_FIND,   KEY_WRAP, '0);
      send_item(OP_INSERT, KEY_WRAP, 16'hA5A5);
      send_item(OP_REMOVE, KEY_WRAP, '0);
      send_item(OP_FIND,   KEY_WRAP, '0);
      send_item(OP_REMOVE, KEY_WRAP, '0);
      send_item(OP_REMOVE, KEY_WRAP, '0);
      send_item(OP_INSERT, 64'd1, 16'h5A5A);
      send_item(OP_INSERT, KEY_MSB, 16'h0001);
      send_item(OP_FIND,   KEY_MSB, '0);
      send_item(OP_FIND,   64'd1, '0);
      send_item(OP_CLEAR,  KEY_TOP, 16'hFFFF);
      send_item(OP_FIND,   64'd1, '0);

      drain_results();

      // Random part, in episodes. The first one fills the table at least to full
      // so that eviction can be reached.
      random_start = items_sent;
      episode      = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (episode == 0) begin
            kind = EP_FILL;
         end else begin
            pick = $urandom_range(0, 9);
            kind = (pick < 4) ? EP_CLUSTER : (pick < 7) ? EP_FILL :
                   (pick < 9) ? EP_NOISE : EP_QUIESCE;
         end
         episode++;
         pool.delete();
         case (kind)
            EP_CLUSTER: begin
               // Keys crowd onto a few neighboring start slots, which builds
               // long probe chains, wraps near the top and holes after removes.
               base   = $urandom_range(0, TABLE_SIZE - 1);
               length = $urandom_range(4, 24);
               for (int n = 0; n < length; n++) begin
                  k = random_key();
                  k = k - (k % TABLE_SIZE) + ((base + $urandom_range(0, 5)) % TABLE_SIZE);
                  if (k == '0) k = KEY_WRAP;
                  pool.push_back(k);
               end
               length = $urandom_range(40, 150);
               for (int n = 0; n < length; n++) begin
                  pick = $urandom_range(0, 99);
                  k    = (pick % 20 == 0) ? random_key() : pool[$urandom_range(0, pool.size() - 1)];
                  if (pick < 40)      send_item(OP_INSERT, k, 16'($urandom));
                  else if (pick < 75) send_item(OP_FIND, k, 16'($urandom));
                  else if (pick < 97) send_item(OP_REMOVE, k, 16'($urandom));
                  else                send_item(OP_CLEAR, k, 16'($urandom));
               end
            end
            EP_FILL: begin
               // Insert past a full table, then mix accesses on the stored
               // keys: hits, removes, refills of holes and evictions.
               if ($urandom_range(0, 1) == 1) send_item(OP_CLEAR, random_key(), 16'($urandom));
               length = TABLE_SIZE + $urandom_range(0, 24);
               for (int n = 0; n < length; n++) begin
                  k = random_key();
                  if (k == '0) k = KEY_TOP;
                  pool.push_back(k);
                  send_item(OP_INSERT, k, 16'($urandom));
               end
               length = $urandom_range(20, 60);
               for (int n = 0; n < length; n++) begin
                  pick = $urandom_range(0, 99);
                  k    = pool[$urandom_range(0, pool.size() - 1)];
                  if (pick < 35)      send_item(OP_FIND, k, 16'($urandom));
                  else if (pick < 55) send_item(OP_REMOVE, k, 16'($urandom));
                  else if (pick < 75) send_item(OP_INSERT, k, 16'($urandom));
                  else                send_item(OP_INSERT, random_key() | 64'd1, 16'($urandom));
               end
            end
            EP_NOISE: begin
               // Unrelated keys, zero keys now and then, and a rare clear.
               length = $urandom_range(20, 60);
               for (int n = 0; n < length; n++) begin
                  pick = $urandom_range(0, 99);
                  k    = ($urandom_range(0, 9) == 0) ? '0 : random_key();
                  if (pick < 5) send_item(OP_CLEAR, k, 16'($urandom));
                  else          send_item(op_type'($urandom_range(0, 2)), k, 16'($urandom));
               end
            end
            default: begin
               drain_results();
               send_item(OP_CLEAR, random_key(), 16'($urandom));
            end
         endcase
      end

      // All stimulus accepted: wait for the last responses, then keep the clock
      // running on an idle block so that any stray beat shows.
      drain_results();
      repeat (TABLE_SIZE + 20) @(negedge clock);
      if (sb.error_count == 0 && sb.pending_count() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/lphc_pkg.sv
rtl/lphc_ctrl.sv
rtl/lphc_datapath.sv
rtl/linear_probe_hash_cache_unit.sv
rtl/lphc_checker.sv
tb/sv/linear_probe_hash_cache_unit_tb.sv
